### design/sliding_window_arq_sender_core_defines.svh
// Assertion macros for the ARQ sender core.
`ifndef SLIDING_WINDOW_ARQ_SENDER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_ARQ_SENDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define SWARQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swarq: implication check failed");
// antecedent holds -> consequent holds in the next cycle
`define SWARQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swarq: next-cycle check failed");
`else
`define SWARQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SWARQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### design/swarq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swarq_pkg;

   localparam int REQ_TYPE_W  = 2;
   localparam int FILE_SIZE_W = 16;
   localparam int SEQ_W       = 6;
   localparam int EVENT_W     = 2;
   localparam int PAYLOAD_W   = 11;
   localparam int PAD_W       = 2;
   localparam int RETRY_W     = 2;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_START   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ACK     = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TIMEOUT = 2'd2;

   // result event codes
   localparam logic [EVENT_W-1:0] EV_SEND   = 2'd0;
   localparam logic [EVENT_W-1:0] EV_GIVEUP = 2'd1;
   localparam logic [EVENT_W-1:0] EV_DONE   = 2'd2;

   localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 2'd3;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]  req_type;
      logic [FILE_SIZE_W-1:0] file_size;
      logic [SEQ_W-1:0]       seq_num;
   } req_item_type;

   typedef struct packed {
      logic [EVENT_W-1:0]   event_res;
      logic [SEQ_W-1:0]     frag_seq;
      logic [PAYLOAD_W-1:0] payload_bytes;
      logic [PAD_W-1:0]     pad_bytes;
      logic                 last;
   } rsp_item_type;

   // per-fragment bookkeeping
   typedef struct packed {
      logic               acked;
      logic [RETRY_W-1:0] resends;
   } frag_ent_type;

endpackage

`default_nettype wire

### design/sliding_window_arq_sender_core.sv
// Sender side of a selective-repeat sliding-window ARQ. A start request
// sizes the file into fragments with a reciprocal multiply by the fragment
// size (quotient first, then the remainder from it) and then issues the
// first window of sends, or gives up when the file needs more than
// MAX_FRAGS fragments; an ack slides the window over every leading acked
// fragment, issuing one send per freed slot while unsent fragments remain
// and a done event once all fragments are acked; a timeout resends one
// fragment or gives up. An ack or timeout on a fragment that is already
// acked ends the request with no result; a request that is ignored at once
// (idle, outside the window, or an unknown code) leaves busy low. All
// fragment bookkeeping is read through one registered read port, one entry
// per cycle, so each slide step reads in ST_SLIDE_RD and decides in
// ST_SLIDE_EV. Each result is shown for one cycle with rsp_valid, the last
// one of a request flagged, held in a pending register and then registered;
// the receiver cannot stall them and must take each result in the cycle it is
// shown. A new start drops any running transfer and clears all fragment
// state at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_arq_sender_core_defines.svh"

module sliding_window_arq_sender_core #(
   parameter int WINDOW     = 8,
   parameter int FRAG_BYTES = 1492,
   parameter int MAX_FRAGS  = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  swarq_pkg::req_item_type          req_data,
   output logic                             rsp_valid,
   output swarq_pkg::rsp_item_type          rsp_data,
   input  wire                              csr_wr_en,
   input  wire [swarq_pkg::RETRY_W-1:0]     csr_wr_data
);

   localparam int FSW  = swarq_pkg::FILE_SIZE_W;
   localparam int SW   = swarq_pkg::SEQ_W;
   localparam int IW   = $clog2(MAX_FRAGS);
   localparam int CW   = $clog2(MAX_FRAGS + 1);
   localparam int CW1  = CW + 1;
   localparam int CMPW = (CW > SW) ? CW : SW;
   localparam int RW   = $clog2(FRAG_BYTES) + 1;
   localparam int PLW  = $clog2(FRAG_BYTES + 1);
   localparam int NFW  = FSW + 2;
   // exact quotient for any FSW-bit size: ceil(2^RSH / FRAG_BYTES), RSH = FSW + log2 ceil
   localparam int RSH  = FSW + $clog2(FRAG_BYTES);
   localparam int RCW  = FSW + 1;
   localparam int PRW  = FSW + RCW;
   localparam int QPW  = 2 * FSW;
   localparam longint unsigned RECIP_L =
      ((64'd1 << RSH) + 64'(FRAG_BYTES) - 64'd1) / 64'(FRAG_BYTES);
   localparam logic [RCW-1:0] RECIP = RCW'(RECIP_L);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DIV      = 9'b000000010,
      ST_NFCHK    = 9'b000000100,
      ST_INIT     = 9'b000001000,
      ST_ACK_CHK  = 9'b000010000,
      ST_TMO_CHK  = 9'b000100000,
      ST_SLIDE_RD = 9'b001000000,
      ST_SLIDE_EV = 9'b010000000,
      ST_FINISH   = 9'b100000000
   } state_type;

   state_type                        state_ff, state_in;
   logic                             active_ff, active_in;
   logic [CW-1:0]                    total_ff, total_in;
   logic [CW-1:0]                    nu_ff, nu_in;
   logic [CW-1:0]                    nts_ff, nts_in;
   logic [swarq_pkg::RETRY_W-1:0]    retry_ff;
   logic [RW-1:0]                    rem_ff, rem_in;
   logic [FSW-1:0]                   size_ff, size_in;
   logic [FSW-1:0]                   quo_ff, quo_in;
   logic                             div_ph_ff, div_ph_in;
   logic [SW-1:0]                    seq_ff, seq_in;

   swarq_pkg::frag_ent_type          ent_mem [MAX_FRAGS];
   logic [MAX_FRAGS-1:0]             ent_vld_ff;
   swarq_pkg::frag_ent_type          ent_q_ff;
   logic                             ent_q_vld_ff;
   swarq_pkg::frag_ent_type          ent_eff;
   logic [IW-1:0]                    rd_idx;
   logic                             mem_we;
   swarq_pkg::frag_ent_type          wr_ent;
   logic                             vld_clr;

   swarq_pkg::rsp_item_type          pend_ff, pend_in;
   logic                             pend_vld_ff, pend_vld_in;
   swarq_pkg::rsp_item_type          rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic                             push, fin;
   swarq_pkg::rsp_item_type          push_item;
   logic                             req_acc;
   logic [CMPW-1:0]                  seq_w;
   logic                             in_win;
   logic [PRW-1:0]                   quo_prod;
   logic [FSW-1:0]                   rem_full;
   logic [NFW-1:0]                   nf;
   logic                             more_to_send;

   function automatic swarq_pkg::rsp_item_type mk_item(
      input logic [swarq_pkg::EVENT_W-1:0] ev,
      input logic [SW-1:0]                 seq,
      input logic [PLW-1:0]                pl
   );
      swarq_pkg::rsp_item_type it;
      it.event_res     = ev;
      it.frag_seq      = seq;
      it.payload_bytes = swarq_pkg::PAYLOAD_W'(pl);
      it.pad_bytes     = 2'(2'd0 - pl[1:0]);
      it.last          = 1'b0;
      return it;
   endfunction

   function automatic swarq_pkg::rsp_item_type mk_send(
      input logic [CW-1:0] n,
      input logic [CW-1:0] total,
      input logic [RW-1:0] rest
   );
      logic [PLW-1:0] pl;
      if (n == '0) begin
         pl = PLW'(2);
      end else if ((CW1'(n) + CW1'(1) == CW1'(total)) && (rest != '0)) begin
         pl = PLW'(rest);
      end else begin
         pl = PLW'(FRAG_BYTES);
      end
      return mk_item(swarq_pkg::EV_SEND, SW'(n), pl);
   endfunction

   assign req_acc  = start && !busy;
   assign seq_w    = CMPW'(req_data.seq_num);
   assign in_win   = (seq_w >= CMPW'(nu_ff)) && (seq_w < CMPW'(nts_ff));
   assign ent_eff  = ent_q_vld_ff ? ent_q_ff : '0;
   assign quo_prod = PRW'(size_ff) * PRW'(RECIP);
   assign rem_full = size_ff - FSW'(QPW'(quo_ff) * QPW'(FRAG_BYTES));
   assign nf       = NFW'(quo_ff) + NFW'(1) + NFW'(rem_ff != '0);
   assign more_to_send = nts_ff < total_ff;
   assign rd_idx   = (state_ff == ST_IDLE) ? IW'(req_data.seq_num) : IW'(nu_ff);

   always_comb begin
      state_in   = state_ff;
      active_in  = active_ff;
      total_in   = total_ff;
      nu_in      = nu_ff;
      nts_in     = nts_ff;
      rem_in     = rem_ff;
      size_in    = size_ff;
      quo_in     = quo_ff;
      div_ph_in  = div_ph_ff;
      seq_in     = seq_ff;
      mem_we     = 1'b0;
      wr_ent     = ent_eff;
      vld_clr    = 1'b0;
      push       = 1'b0;
      push_item  = mk_item(swarq_pkg::EV_DONE, '0, '0);
      fin        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               seq_in = req_data.seq_num;
               unique case (req_data.req_type)
                  swarq_pkg::REQ_START: begin
                     active_in  = 1'b0;
                     nu_in      = '0;
                     nts_in     = '0;
                     vld_clr    = 1'b1;
                     rem_in     = '0;
                     size_in    = req_data.file_size;
                     div_ph_in  = 1'b0;
                     state_in   = ST_DIV;
                  end
                  swarq_pkg::REQ_ACK: begin
                     if (active_ff && in_win) begin
                        state_in = ST_ACK_CHK;
                     end
                  end
                  swarq_pkg::REQ_TIMEOUT: begin
                     if (active_ff && in_win) begin
                        state_in = ST_TMO_CHK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            // quotient by reciprocal multiply, then the remainder from it
            if (!div_ph_ff) begin
               quo_in    = FSW'(quo_prod >> RSH);
               div_ph_in = 1'b1;
            end else begin
               rem_in   = RW'(rem_full);
               state_in = ST_NFCHK;
            end
         end
         ST_NFCHK: begin
            if (nf > NFW'(MAX_FRAGS)) begin
               push      = 1'b1;
               push_item = mk_item(swarq_pkg::EV_GIVEUP, '0, '0);
               total_in  = '0;
               state_in  = ST_FINISH;
            end else begin
               active_in = 1'b1;
               total_in  = CW'(nf);
               state_in  = ST_INIT;
            end
         end
         ST_INIT: begin
            if (more_to_send && (32'(nts_ff) < 32'(WINDOW))) begin
               push      = 1'b1;
               push_item = mk_send(nts_ff, total_ff, rem_ff);
               nts_in    = nts_ff + CW'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_ACK_CHK: begin
            if (ent_eff.acked) begin
               state_in = ST_IDLE;
            end else begin
               mem_we       = 1'b1;
               wr_ent.acked = 1'b1;
               state_in     = ST_SLIDE_RD;
            end
         end
         ST_SLIDE_RD: begin
            state_in = ST_SLIDE_EV;
         end
         ST_SLIDE_EV: begin
            if ((nu_ff < total_ff) && ent_eff.acked) begin
               nu_in = nu_ff + CW'(1);
               if (more_to_send) begin
                  push      = 1'b1;
                  push_item = mk_send(nts_ff, total_ff, rem_ff);
                  nts_in    = nts_ff + CW'(1);
               end
               state_in = ST_SLIDE_RD;
            end else begin
               if (nu_ff >= total_ff) begin
                  push      = 1'b1;
                  push_item = mk_item(swarq_pkg::EV_DONE, '0, '0);
                  active_in = 1'b0;
               end
               state_in = ST_FINISH;
            end
         end
         ST_TMO_CHK: begin
            if (ent_eff.acked) begin
               state_in = ST_IDLE;
            end else begin
               if (ent_eff.resends >= retry_ff) begin
                  push      = 1'b1;
                  push_item = mk_item(swarq_pkg::EV_GIVEUP, seq_ff, '0);
                  active_in = 1'b0;
               end else begin
                  mem_we         = 1'b1;
                  wr_ent.resends = ent_eff.resends + swarq_pkg::RETRY_W'(1);
                  push           = 1'b1;
                  push_item      = mk_send(CW'(seq_ff), total_ff, rem_ff);
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            fin      = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // one result held back so the last of a request can be flagged
   always_comb begin
      rsp_in       = pend_ff;
      rsp_in.last  = fin;
      rsp_valid_in = pend_vld_ff && (push || fin);
      pend_in      = push ? push_item : pend_ff;
      if (push) begin
         pend_vld_in = 1'b1;
      end else if (fin) begin
         pend_vld_in = 1'b0;
      end else begin
         pend_vld_in = pend_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         total_ff     <= '0;
         nu_ff        <= '0;
         nts_ff       <= '0;
         retry_ff     <= swarq_pkg::RETRY_LIMIT_RST;
         ent_vld_ff   <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         total_ff     <= total_in;
         nu_ff        <= nu_in;
         nts_ff       <= nts_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            retry_ff <= csr_wr_data;
         end
         if (vld_clr) begin
            ent_vld_ff <= '0;
         end else if (mem_we) begin
            ent_vld_ff[IW'(seq_ff)] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      size_ff    <= size_in;
      quo_ff     <= quo_in;
      div_ph_ff  <= div_ph_in;
      seq_ff     <= seq_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   // fragment bookkeeping memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ent_mem[IW'(seq_ff)] <= wr_ent;
      end
      ent_q_ff     <= ent_mem[rd_idx];
      ent_q_vld_ff <= ent_vld_ff[rd_idx];
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SWARQ_ASSERT_IMPLY(a_last_drains, clock, reset, rsp_valid_ff && rsp_ff.last, !pend_vld_ff)
   `SWARQ_ASSERT_IMPLY(a_idle_empty, clock, reset, state_ff == ST_IDLE, !pend_vld_ff)
   `SWARQ_ASSERT_IMPLY(a_window_order, clock, reset, active_ff, (nu_ff <= nts_ff) && (nts_ff <= total_ff))
   `SWARQ_ASSERT_NEXT(a_start_divides, clock, reset, req_acc && (req_data.req_type == swarq_pkg::REQ_START), (state_ff == ST_DIV) && !active_ff)

endmodule

`default_nettype wire
